// ----- hdl/pcc_pkg.sv -----
// Package for the polar/Cartesian converter: widths, CORDIC constants, codes.
// No dependencies.
`default_nettype none
package pcc_pkg;
   localparam int DefaultSteps = 24;
   localparam int DefaultDataBits = 32;
   localparam int AccBits = 52;

   typedef enum logic [1:0] {
      FUNC_P2C = 2'd0,
      FUNC_C2P = 2'd1,
      FUNC_JAC = 2'd2,
      FUNC_NONE = 2'd3
   } func_type;

   localparam logic signed [35:0] PiQ29 = 36'sd1686629713;
   localparam logic signed [35:0] HalfPiQ29 = 36'sd843314857;
   localparam logic signed [35:0] TwoPiQ29 = 36'sd3373259426;

   function automatic logic signed [35:0] atan_q29(input int i);
      logic signed [35:0] r;
      case (i)
         0: r = 36'sd421657428;
         1: r = 36'sd248918915;
         2: r = 36'sd131521918;
         3: r = 36'sd66762579;
         4: r = 36'sd33510843;
         5: r = 36'sd16771758;
         6: r = 36'sd8387925;
         7: r = 36'sd4194219;
         8: r = 36'sd2097141;
         9: r = 36'sd1048575;
         10: r = 36'sd524288;
         11: r = 36'sd262144;
         12: r = 36'sd131072;
         13: r = 36'sd65536;
         14: r = 36'sd32768;
         15: r = 36'sd16384;
         16: r = 36'sd8192;
         17: r = 36'sd4096;
         18: r = 36'sd2048;
         19: r = 36'sd1024;
         20: r = 36'sd512;
         21: r = 36'sd256;
         22: r = 36'sd128;
         23: r = 36'sd64;
         24: r = 36'sd32;
         25: r = 36'sd16;
         26: r = 36'sd8;
         27: r = 36'sd4;
         28: r = 36'sd2;
         29: r = 36'sd1;
         30: r = 36'sd1;
         default: r = 36'sd0;
      endcase
      return r;
   endfunction

   // Integer square root by the bit-pair method; elaboration use only.
   function automatic longint unsigned isqrt64(input longint unsigned n);
      longint unsigned res, bit_v, m;
      res = 0;
      m = n;
      bit_v = 64'd1 << 62;
      while (bit_v > m) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (m >= res + bit_v) begin
            m = m - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // Reciprocal of the CORDIC gain in Q30, rounded by a shift-and-subtract division; elaboration use only.
   function automatic longint unsigned gain_q30(input int steps);
      longint unsigned p, s, num, rem, quo;
      p = 64'd1 << 60;
      for (int i = 0; i < steps; i++) p = p + (p >> (2 * i));
      s = isqrt64(p);
      num = (64'd1 << 60) + (s >> 1);
      rem = 0;
      quo = 0;
      for (int b = 63; b >= 0; b--) begin
         rem = (rem << 1) | 64'(num[b]);
         if (rem >= s) begin
            rem = rem - s;
            quo = quo | (64'd1 << b);
         end
      end
      return quo;
   endfunction

   typedef struct packed {
      logic     valid;
      func_type func;
      logic     zero;
      logic     neg_a;
      logic     neg_b;
   } ctl_type;
endpackage
`default_nettype wire

// ----- hdl/pcc_stream_if.sv -----
// Valid/ready stream interfaces for request and result channels.
// Depends on nothing.
`default_nettype none
interface pcc_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        func;
   logic signed [31:0] first_value;
   logic signed [31:0] second_value;
   modport source(output valid, func, first_value, second_value, input ready);
   modport sink(input valid, func, first_value, second_value, output ready);
endinterface

interface pcc_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] out_a;
   logic signed [31:0] out_b;
   logic signed [31:0] out_c;
   logic signed [31:0] out_d;
   logic              overflow;
   modport source(output valid, out_a, out_b, out_c, out_d, overflow, input ready);
   modport sink(input valid, out_a, out_b, out_c, out_d, overflow, output ready);
endinterface
`default_nettype wire

// ----- hdl/pcc_stage.sv -----
// One registered CORDIC micro-rotation for two lanes sharing one angle.
// Depends on pcc_pkg.
`default_nettype none
module pcc_stage
   import pcc_pkg::*;
#(
   parameter int Shift = 0
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      enable,
   input  wire ctl_type                   ctl_in,
   input  wire logic signed [AccBits-1:0] x0_in_d,
   input  wire logic signed [AccBits-1:0] y0_in_d,
   input  wire logic signed [AccBits-1:0] x1_in_d,
   input  wire logic signed [AccBits-1:0] y1_in_d,
   input  wire logic signed [35:0]        z_in_d,
   output ctl_type                        ctl_out,
   output logic signed [AccBits-1:0]      x0_out,
   output logic signed [AccBits-1:0]      y0_out,
   output logic signed [AccBits-1:0]      x1_out,
   output logic signed [AccBits-1:0]      y1_out,
   output logic signed [35:0]             z_out
);
   localparam logic signed [35:0] Atan = atan_q29(Shift);
   logic dir;
   logic signed [AccBits-1:0] x0_in, y0_in, x1_in, y1_in;
   logic signed [35:0] z_in;
   ctl_type ctl_ff;
   logic signed [AccBits-1:0] x0_ff, y0_ff, x1_ff, y1_ff;
   logic signed [35:0] z_ff;

   always_comb begin
      // Vectoring drives y to zero; rotation drives the angle to zero.
      if (ctl_in.func == FUNC_C2P) dir = y0_in_d[AccBits-1];
      else dir = ~z_in_d[35];
      if (dir) begin
         x0_in = x0_in_d - (y0_in_d >>> Shift);
         y0_in = y0_in_d + (x0_in_d >>> Shift);
         x1_in = x1_in_d - (y1_in_d >>> Shift);
         y1_in = y1_in_d + (x1_in_d >>> Shift);
         z_in = z_in_d - Atan;
      end else begin
         x0_in = x0_in_d + (y0_in_d >>> Shift);
         y0_in = y0_in_d - (x0_in_d >>> Shift);
         x1_in = x1_in_d + (y1_in_d >>> Shift);
         y1_in = y1_in_d - (x1_in_d >>> Shift);
         z_in = z_in_d + Atan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (enable) begin
         ctl_ff <= ctl_in;
      end
      if (enable) begin
         x0_ff <= x0_in;
         y0_ff <= y0_in;
         x1_ff <= x1_in;
         y1_ff <= y1_in;
         z_ff <= z_in;
      end
   end

   assign ctl_out = ctl_ff;
   assign x0_out = x0_ff;
   assign y0_out = y0_ff;
   assign x1_out = x1_ff;
   assign y1_out = y1_ff;
   assign z_out = z_ff;
endmodule
`default_nettype wire

// ----- hdl/pcc_scale.sv -----
// Gain scaling with rounding and Q16.16 saturation, one registered stage.
// Depends on pcc_pkg.
`default_nettype none
module pcc_scale
   import pcc_pkg::*;
#(
   parameter int Guard = 8,
   parameter longint unsigned Gain = 64'd652032874
) (
   input  wire logic                      clock,
   input  wire logic                      enable,
   input  wire logic signed [AccBits-1:0] value,
   output logic signed [31:0]             result,
   output logic                           sat
);
   localparam int Sh = 30 + Guard;
   logic neg_in, neg_ff;
   logic [AccBits-1:0] mag;
   logic [57:0] hi_in, hi_ff;
   logic [54:0] lo_in, lo_ff;
   logic [63:0] lo_sum, q;
   logic [31:0] gk;

   assign gk = Gain[31:0];
   always_comb begin
      neg_in = value[AccBits-1];
      mag = neg_in ? AccBits'(-value) : AccBits'(value);
      hi_in = 58'(mag >> 24) * 58'(gk);
      lo_in = 55'(mag[23:0]) * 55'(gk) + (55'(1) << (Sh - 1));
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         neg_ff <= neg_in;
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
   end

   always_comb begin
      lo_sum = (64'(hi_ff & ((58'(1) << (Sh - 24)) - 58'(1))) << 24) + 64'(lo_ff);
      q = 64'(hi_ff >> (Sh - 24)) + (lo_sum >> Sh);
      sat = 1'b0;
      if (!neg_ff) begin
         if (q > 64'h7FFF_FFFF) begin
            sat = 1'b1;
            result = 32'sh7FFF_FFFF;
         end else begin
            result = q[31:0];
         end
      end else if (q > 64'h8000_0000) begin
         sat = 1'b1;
         result = 32'sh8000_0000;
      end else begin
         result = -q[31:0];
      end
   end
endmodule
`default_nettype wire

// ----- hdl/polar_cartesian_converter.sv -----
// Top level of the polar/Cartesian converter: pre-rotation, CORDIC pipeline,
// gain scaling and output register. Depends on pcc_pkg, pcc_stage, pcc_scale, pcc_stream_if.
`default_nettype none
// Accepts one request per clock while the output is not stalled and returns one
// result per request in order. The pipeline is one pre-fold stage, one register
// per micro-rotation, one gain-multiply stage and the output register. The whole
// pipeline advances whenever the output register is empty or being taken.
module polar_cartesian_converter
   import pcc_pkg::*;
#(
   parameter int CORDIC_STEPS = DefaultSteps,
   parameter int DATA_BITS = DefaultDataBits
) (
   input wire logic clock,
   input wire logic reset,
   pcc_req_if.sink   req,
   pcc_rsp_if.source rsp
);
   localparam int Steps = CORDIC_STEPS > 32 ? 32 : (CORDIC_STEPS < 1 ? 1 : CORDIC_STEPS);
   localparam int GuardRaw = (DATA_BITS - 16) / 2;
   localparam int Guard = GuardRaw > 16 ? 16 : (GuardRaw < 0 ? 0 : GuardRaw);
   localparam longint unsigned Gain = gain_q30(Steps);

   logic advance;
   assign advance = !rsp.valid || rsp.ready;
   assign req.ready = advance;

   ctl_type ctl_in, ctl_ff;
   logic signed [AccBits-1:0] x0_in, y0_in, x1_in, y1_in;
   logic signed [AccBits-1:0] x0_ff, y0_ff, x1_ff, y1_ff;
   logic signed [35:0] z_in, z_ff;
   logic signed [35:0] th;
   logic signed [AccBits-1:0] a_s, b_s, unit_s;

   always_comb begin
      a_s = AccBits'(req.first_value) <<< Guard;
      b_s = AccBits'(req.second_value) <<< Guard;
      unit_s = AccBits'(65536) <<< Guard;
      ctl_in.valid = req.valid;
      ctl_in.func = func_type'(req.func);
      ctl_in.zero = (req.first_value == 32'sd0) && (req.second_value == 32'sd0);
      ctl_in.neg_a = 1'b0;
      ctl_in.neg_b = 1'b0;
      th = 36'(req.second_value);
      if (th > PiQ29) th = th - TwoPiQ29;
      else if (th < -PiQ29) th = th + TwoPiQ29;
      if (th > HalfPiQ29) begin
         th = th - PiQ29;
         ctl_in.neg_a = 1'b1;
      end else if (th < -HalfPiQ29) begin
         th = th + PiQ29;
         ctl_in.neg_a = 1'b1;
      end
      x0_in = a_s;
      y0_in = '0;
      x1_in = unit_s;
      y1_in = '0;
      z_in = th;
      if (ctl_in.func == FUNC_C2P) begin
         ctl_in.neg_a = 1'b0;
         x0_in = a_s;
         y0_in = b_s;
         z_in = '0;
         if (req.first_value < 0) begin
            x0_in = -a_s;
            y0_in = -b_s;
            z_in = (req.second_value >= 0) ? PiQ29 : -PiQ29;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
      if (advance) begin
         x0_ff <= x0_in;
         y0_ff <= y0_in;
         x1_ff <= x1_in;
         y1_ff <= y1_in;
         z_ff <= z_in;
      end
   end

   ctl_type ctl_p [Steps+1];
   logic signed [AccBits-1:0] x0_p [Steps+1];
   logic signed [AccBits-1:0] y0_p [Steps+1];
   logic signed [AccBits-1:0] x1_p [Steps+1];
   logic signed [AccBits-1:0] y1_p [Steps+1];
   logic signed [35:0] z_p [Steps+1];

   assign ctl_p[0] = ctl_ff;
   assign x0_p[0] = x0_ff;
   assign y0_p[0] = y0_ff;
   assign x1_p[0] = x1_ff;
   assign y1_p[0] = y1_ff;
   assign z_p[0] = z_ff;

   for (genvar g = 0; g < Steps; g++) begin : g_stage
      pcc_stage #(.Shift(g)) u_stage (
         .clock(clock), .reset(reset), .enable(advance),
         .ctl_in(ctl_p[g]), .x0_in_d(x0_p[g]), .y0_in_d(y0_p[g]),
         .x1_in_d(x1_p[g]), .y1_in_d(y1_p[g]), .z_in_d(z_p[g]),
         .ctl_out(ctl_p[g+1]), .x0_out(x0_p[g+1]), .y0_out(y0_p[g+1]),
         .x1_out(x1_p[g+1]), .y1_out(y1_p[g+1]), .z_out(z_p[g+1])
      );
   end

   ctl_type ctl_e;
   logic signed [AccBits-1:0] ea, eb, ec, ed;
   logic signed [AccBits-1:0] xa, ya, xu, yu;
   logic signed [35:0] z_e;
   assign ctl_e = ctl_p[Steps];
   assign xa = ctl_e.neg_a ? -x0_p[Steps] : x0_p[Steps];
   assign ya = ctl_e.neg_a ? -y0_p[Steps] : y0_p[Steps];
   assign xu = ctl_e.neg_a ? -x1_p[Steps] : x1_p[Steps];
   assign yu = ctl_e.neg_a ? -y1_p[Steps] : y1_p[Steps];

   always_comb begin
      ea = xa;
      eb = ya;
      ec = '0;
      ed = '0;
      if (ctl_e.func == FUNC_JAC) begin
         ea = xu;
         eb = -ya;
         ec = yu;
         ed = xa;
      end
   end
   assign z_e = z_p[Steps];

   logic signed [31:0] ra, rb, rc, rd;
   logic sa, sb, sc, sd;
   ctl_type ctl_m;
   logic signed [31:0] z_m;

   pcc_scale #(.Guard(Guard), .Gain(Gain)) u_sa (.clock(clock), .enable(advance),
      .value(ea), .result(ra), .sat(sa));
   pcc_scale #(.Guard(Guard), .Gain(Gain)) u_sb (.clock(clock), .enable(advance),
      .value(eb), .result(rb), .sat(sb));
   pcc_scale #(.Guard(Guard), .Gain(Gain)) u_sc (.clock(clock), .enable(advance),
      .value(ec), .result(rc), .sat(sc));
   pcc_scale #(.Guard(Guard), .Gain(Gain)) u_sd (.clock(clock), .enable(advance),
      .value(ed), .result(rd), .sat(sd));

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_m.valid <= 1'b0;
      end else if (advance) begin
         ctl_m <= ctl_e;
      end
      if (advance) z_m <= z_e[31:0];
   end

   logic rsp_valid_ff;
   logic signed [31:0] a_ff, b_ff, c_ff, d_ff;
   logic ovf_ff;
   logic signed [31:0] a_in, b_in, c_in, d_in;
   logic ovf_in;

   always_comb begin
      a_in = '0;
      b_in = '0;
      c_in = '0;
      d_in = '0;
      ovf_in = 1'b0;
      case (ctl_m.func)
         FUNC_P2C: begin
            a_in = ra;
            b_in = rb;
            ovf_in = sa | sb;
         end
         FUNC_C2P: begin
            if (!ctl_m.zero) begin
               a_in = ra;
               b_in = z_m;
               ovf_in = sa;
            end
         end
         FUNC_JAC: begin
            a_in = ra;
            b_in = rb;
            c_in = rc;
            d_in = rd;
            ovf_in = sa | sb | sc | sd;
         end
         default: begin
            ovf_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= ctl_m.valid;
      end
      if (advance) begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
         d_ff <= d_in;
         ovf_ff <= ovf_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.out_a = a_ff;
   assign rsp.out_b = b_ff;
   assign rsp.out_c = c_ff;
   assign rsp.out_d = d_ff;
   assign rsp.overflow = ovf_ff;

`ifndef SYNTHESIS
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.out_a))
      else $error("result changed while stalled");
   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      req.ready == (!rsp.valid || rsp.ready))
      else $error("request ready does not follow output space");
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      advance && ctl_m.valid && ctl_m.func == FUNC_NONE |=> !rsp.overflow && rsp.out_a == 0)
      else $error("unused code gave a result");
   a_c_zero: assert property (@(posedge clock) disable iff (reset)
      advance && ctl_m.valid && ctl_m.func != FUNC_JAC |=> rsp.out_c == 0 && rsp.out_d == 0)
      else $error("Jacobian fields set outside Jacobian");
`endif
endmodule
`default_nettype wire
